// ===== hw/rtl/quadtree_block_triangulation_assert.svh =====
// ----------------------------------------------------------------------------
// Quadtree block triangulation assertion macros
// Short forms for the concurrent checks used in the top level.
// ----------------------------------------------------------------------------
`ifndef QUADTREE_BLOCK_TRIANGULATION_ASSERT_SVH
`define QUADTREE_BLOCK_TRIANGULATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define QBT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qbt: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define QBT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qbt: next-cycle check failed");

`endif

// ===== hw/rtl/qbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadtree block triangulation package
// Shared types, codes and helper functions of the triangulation block.
// ----------------------------------------------------------------------------
package qbt_pkg;

   localparam int unsigned DEF_MAX_LEVELS = 8;
   localparam int unsigned LEVEL_W        = 4;
   localparam int unsigned COORD_W        = 8;
   localparam int unsigned PROBE_W        = COORD_W + 1;
   localparam int unsigned VERT_W         = 15;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd8;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 4'd2;

   // Command codes.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_BLOCK = 2'd2;

   // Neighbor directions, also the order in which fan sides are emitted.
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // Point codes: upper two bits select min/mid/max row, lower two the column.
   localparam logic [3:0] PT_TL = 4'b0000;
   localparam logic [3:0] PT_TM = 4'b0001;
   localparam logic [3:0] PT_TR = 4'b0010;
   localparam logic [3:0] PT_ML = 4'b0100;
   localparam logic [3:0] PT_C  = 4'b0101;
   localparam logic [3:0] PT_MR = 4'b0110;
   localparam logic [3:0] PT_BL = 4'b1000;
   localparam logic [3:0] PT_BM = 4'b1001;
   localparam logic [3:0] PT_BR = 4'b1010;

   localparam logic [1:0] SEL_MIN = 2'd0;
   localparam logic [1:0] SEL_MID = 2'd1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [COORD_W-1:0] row_start;
      logic [COORD_W-1:0] col_start;
      logic [COORD_W-1:0] row_end;
      logic [COORD_W-1:0] col_end;
   } req_type;

   typedef struct packed {
      logic [VERT_W-1:0] vert_a;
      logic [VERT_W-1:0] vert_b;
      logic [VERT_W-1:0] vert_c;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic en;
      logic we;
      logic wdata;
   } mark_ctl_type;

   typedef struct packed {
      logic [COORD_W-1:0] imin;
      logic [COORD_W-1:0] imid;
      logic [COORD_W-1:0] imax;
      logic [COORD_W-1:0] jmin;
      logic [COORD_W-1:0] jmid;
      logic [COORD_W-1:0] jmax;
   } geom_type;

   typedef struct packed {
      logic [3:0] pa;
      logic [3:0] pb;
      logic [3:0] pc;
      logic       last;
   } tri_type;

   // Corner points of one triangle. In quad mode the half bit picks one of
   // the two diagonal triangles; otherwise dir is the fan side, split says
   // whether that side is cut at its midpoint and half picks the piece.
   function automatic tri_type tri_pick(input logic quad, input logic [1:0] dir,
                                        input logic split, input logic half);
      tri_type t;
      t = '{pa: PT_TL, pb: PT_BL, pc: PT_BR, last: 1'b0};
      if (quad) begin
         if (half) begin
            t.pb = PT_BR;
            t.pc = PT_TR;
         end
      end else begin
         case (dir)
            DIR_UP: begin
               if (!split) t = '{pa: PT_TL, pb: PT_C, pc: PT_TR, last: 1'b0};
               else if (!half) t = '{pa: PT_TL, pb: PT_C, pc: PT_TM, last: 1'b0};
               else t = '{pa: PT_TM, pb: PT_C, pc: PT_TR, last: 1'b0};
            end
            DIR_DOWN: begin
               if (!split) t = '{pa: PT_C, pb: PT_BL, pc: PT_BR, last: 1'b0};
               else if (!half) t = '{pa: PT_C, pb: PT_BL, pc: PT_BM, last: 1'b0};
               else t = '{pa: PT_C, pb: PT_BM, pc: PT_BR, last: 1'b0};
            end
            DIR_LEFT: begin
               if (!split) t = '{pa: PT_C, pb: PT_TL, pc: PT_BL, last: 1'b0};
               else if (!half) t = '{pa: PT_C, pb: PT_TL, pc: PT_ML, last: 1'b0};
               else t = '{pa: PT_C, pb: PT_ML, pc: PT_BL, last: 1'b0};
            end
            default: begin
               if (!split) t = '{pa: PT_C, pb: PT_BR, pc: PT_TR, last: 1'b0};
               else if (!half) t = '{pa: PT_C, pb: PT_MR, pc: PT_TR, last: 1'b0};
               else t = '{pa: PT_C, pb: PT_BR, pc: PT_MR, last: 1'b0};
            end
         endcase
      end
      return t;
   endfunction

   // Vertex index row * (2^sh + 1) + col, kept to the index width.
   function automatic logic [VERT_W-1:0] vert_index(input logic [COORD_W-1:0] r,
                                                    input logic [COORD_W-1:0] c,
                                                    input logic [LEVEL_W-1:0] sh);
      return (VERT_W'(r) << sh) + VERT_W'(r) + VERT_W'(c);
   endfunction

endpackage

// ===== hw/rtl/quadtree_block_triangulation.sv =====
// ----------------------------------------------------------------------------
// Quadtree block triangulation
// Split-mark bitmap over the terrain vertex grid and a triangulator that
// emits each block as two diagonal triangles or a four-sided fan.
// ----------------------------------------------------------------------------
// Usage. Words enter on the req_ channel (valid/ready) and leave on the rsp_
// channel (valid/ready); csr_ carries the four-bit level count and is always
// ready. A set or clear mark word inside the grid writes one bit of the mark
// memory in the cycle it is taken; it gives no result and the next word is
// taken in the following cycle. A valid block word makes the block busy: a
// block one row tall goes straight to emitting, any other block first reads
// its four neighbors from the single-port mark memory, one per cycle, and
// then passes a settle state. Triangles then leave one per cycle while the
// receiver takes them, up to eight, the final one with last set. The next
// word is accepted once the last triangle sits in the output register, even
// if the receiver has not taken it yet. A stalled receiver holds the output
// word and the block waits with it. After reset a sweep clears all
// (2^(MAX_LEVELS-1)+1)^2 entries of the mark memory, 16641 at the default,
// during which no word is accepted; level count returns to 8.
// ----------------------------------------------------------------------------
`include "quadtree_block_triangulation_assert.svh"

module quadtree_block_triangulation #(
   parameter int unsigned MAX_LEVELS = qbt_pkg::DEF_MAX_LEVELS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  qbt_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output qbt_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [qbt_pkg::LEVEL_W-1:0] csr_data
);
   import qbt_pkg::*;

   localparam int unsigned MAX_SIDE = (1 << (MAX_LEVELS - 1)) + 1;
   localparam int unsigned DEPTH    = MAX_SIDE * MAX_SIDE;
   localparam int unsigned AW       = $clog2(DEPTH);
   // Wide enough for the largest grid side and for a probe coordinate.
   localparam int unsigned CMP_W    = (MAX_LEVELS > PROBE_W) ? MAX_LEVELS : PROBE_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PROBE  = 2'd1;
   localparam logic [1:0] ST_SETTLE = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   geom_type           geom_ff, geom_in;
   logic [COORD_W-1:0] rs_ff, rs_in, cs_ff, cs_in;
   logic               span1_ff, span1_in;
   logic [1:0]         probe_ff, probe_in;
   logic [3:0]         flags_ff, flags_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [1:0]         rd_dir_ff, rd_dir_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [1:0]         dir_ff, dir_in;
   logic               half_ff, half_in;

   logic [LEVEL_W-1:0] lv_eff;
   logic [LEVEL_W-1:0] vert_shift;
   logic [CMP_W-1:0]   side;
   logic               accept;
   logic               is_mark;
   logic               mark_ok;
   logic               blk_ok;
   logic [COORD_W-1:0] req_imid, req_jmid;
   logic [PROBE_W-1:0] prow, pcol;
   logic               probe_ok;
   logic [PROBE_W-1:0] arow, acol;
   logic [AW-1:0]      mem_addr;
   mark_ctl_type       mem_ctl;
   logic               mem_rdata;
   logic               mem_clr_busy;
   logic               quad;
   logic               cur_split;
   tri_type            tri_cur;
   logic               tri_load;
   logic               slot_free;
   logic               emit_done;

   // ---------------------------------------------------------------- config
   // Level counts outside the supported range act as the nearest bound.
   always_comb begin
      if (level_ff < LEVEL_MIN) begin
         lv_eff = LEVEL_MIN;
      end else if (level_ff > LEVEL_W'(MAX_LEVELS)) begin
         lv_eff = LEVEL_W'(MAX_LEVELS);
      end else begin
         lv_eff = level_ff;
      end
   end

   assign vert_shift = lv_eff - LEVEL_W'(1);
   assign side       = (CMP_W'(1) << vert_shift) + CMP_W'(1);
   assign csr_ready  = 1'b1;
   assign level_in   = csr_valid ? csr_data : level_ff;

   // --------------------------------------------------------- input decode
   assign req_ready = (state_ff == ST_IDLE) && !mem_clr_busy;
   assign accept    = req_valid && req_ready;
   assign is_mark   = (req_data.cmd == CMD_CLEAR) || (req_data.cmd == CMD_SET);
   assign mark_ok   = (CMP_W'(req_data.row_start) < side) &&
                      (CMP_W'(req_data.col_start) < side);
   assign blk_ok    = (req_data.cmd == CMD_BLOCK) &&
                      (CMP_W'(req_data.row_end) < side) &&
                      (CMP_W'(req_data.col_end) < side) &&
                      (req_data.row_end > req_data.row_start) &&
                      (req_data.col_end > req_data.col_start);
   assign req_imid  = COORD_W'((PROBE_W'(req_data.row_start) +
                                PROBE_W'(req_data.row_end)) >> 1);
   assign req_jmid  = COORD_W'((PROBE_W'(req_data.col_start) +
                                PROBE_W'(req_data.col_end)) >> 1);

   // -------------------------------------------------------- neighbor probe
   // Same-size neighbor centers one span away; outside the grid they count
   // as unsplit and no read is issued.
   always_comb begin
      prow     = PROBE_W'(geom_ff.imid);
      pcol     = PROBE_W'(geom_ff.jmid);
      probe_ok = 1'b0;
      unique case (probe_ff)
         DIR_UP: begin
            prow     = PROBE_W'(geom_ff.imid) - PROBE_W'(rs_ff);
            probe_ok = geom_ff.imid >= rs_ff;
         end
         DIR_DOWN: begin
            prow     = PROBE_W'(geom_ff.imid) + PROBE_W'(rs_ff);
            probe_ok = CMP_W'(prow) < side;
         end
         DIR_LEFT: begin
            pcol     = PROBE_W'(geom_ff.jmid) - PROBE_W'(cs_ff);
            probe_ok = geom_ff.jmid >= cs_ff;
         end
         default: begin
            pcol     = PROBE_W'(geom_ff.jmid) + PROBE_W'(cs_ff);
            probe_ok = CMP_W'(pcol) < side;
         end
      endcase
   end

   // Marks are kept at the stride of the largest grid, so they stay in place
   // when the level count changes.
   assign arow     = (state_ff == ST_IDLE) ? PROBE_W'(req_data.row_start) : prow;
   assign acol     = (state_ff == ST_IDLE) ? PROBE_W'(req_data.col_start) : pcol;
   assign mem_addr = (AW'(arow) << (MAX_LEVELS - 1)) + AW'(arow) + AW'(acol);

   assign mem_ctl.en    = (accept && is_mark && mark_ok) ||
                          ((state_ff == ST_PROBE) && probe_ok);
   assign mem_ctl.we    = (state_ff == ST_IDLE);
   assign mem_ctl.wdata = (req_data.cmd == CMD_SET);

   qbt_mark_mem #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_mark_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mem_ctl),
      .addr     (mem_addr),
      .rdata    (mem_rdata),
      .clr_busy (mem_clr_busy)
   );

   // ------------------------------------------------------------ emission
   // A block one row tall, or one with no split neighbor, is two triangles
   // across the diagonal; otherwise the sides go up, down, left, right, each
   // as one fan triangle or two when that neighbor is split.
   assign quad      = span1_ff || (flags_ff == 4'b0000);
   assign cur_split = flags_ff[dir_ff];
   assign emit_done = quad ? half_ff : ((dir_ff == DIR_RIGHT) && (!cur_split || half_ff));
   assign tri_load  = (state_ff == ST_EMIT) && slot_free;

   always_comb begin
      tri_cur      = tri_pick(quad, dir_ff, cur_split, half_ff);
      tri_cur.last = emit_done;
   end

   qbt_vert_unit u_vert_unit (
      .clock      (clock),
      .reset      (reset),
      .tri_load   (tri_load),
      .tri_in     (tri_cur),
      .geom       (geom_ff),
      .vert_shift (vert_shift),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .slot_free  (slot_free)
   );

   // ------------------------------------------------------------- sequencer
   always_comb begin
      state_in  = state_ff;
      geom_in   = geom_ff;
      rs_in     = rs_ff;
      cs_in     = cs_ff;
      span1_in  = span1_ff;
      probe_in  = probe_ff;
      flags_in  = flags_ff;
      dir_in    = dir_ff;
      half_in   = half_ff;
      rd_vld_in = (state_ff == ST_PROBE);
      rd_dir_in = probe_ff;
      rd_ok_in  = probe_ok;

      // Read data of the previous probe lands here.
      if (rd_vld_ff) begin
         flags_in[rd_dir_ff] = rd_ok_ff && mem_rdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && blk_ok) begin
               geom_in.imin = req_data.row_start;
               geom_in.imax = req_data.row_end;
               geom_in.imid = req_imid;
               geom_in.jmin = req_data.col_start;
               geom_in.jmax = req_data.col_end;
               geom_in.jmid = req_jmid;
               rs_in        = req_data.row_end - req_data.row_start;
               cs_in        = req_data.col_end - req_data.col_start;
               span1_in     = (PROBE_W'(req_data.row_start) + PROBE_W'(1)) ==
                              PROBE_W'(req_data.row_end);
               flags_in     = 4'b0000;
               probe_in     = DIR_UP;
               dir_in       = DIR_UP;
               half_in      = 1'b0;
               state_in     = span1_in ? ST_EMIT : ST_PROBE;
            end
         end
         ST_PROBE: begin
            probe_in = probe_ff + 2'd1;
            if (probe_ff == DIR_RIGHT) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_EMIT;
         end
         default: begin
            if (tri_load) begin
               if (emit_done) begin
                  state_in = ST_IDLE;
               end else if ((quad || cur_split) && !half_ff) begin
                  half_in = 1'b1;
               end else begin
                  half_in = 1'b0;
                  dir_in  = dir_ff + 2'd1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         level_ff  <= LEVEL_RESET;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         level_ff  <= level_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      geom_ff   <= geom_in;
      rs_ff     <= rs_in;
      cs_ff     <= cs_in;
      span1_ff  <= span1_in;
      probe_ff  <= probe_in;
      flags_ff  <= flags_in;
      rd_dir_ff <= rd_dir_in;
      rd_ok_ff  <= rd_ok_in;
      dir_ff    <= dir_in;
      half_ff   <= half_in;
   end

   // ------------------------------------------------------------ assertions
   // Nothing can leave the block before the mark memory sweep has finished.
   `QBT_ASSERT_IMPLY(a_no_rsp_in_sweep, clock, reset, mem_clr_busy, !rsp_valid)
   // Probe read data only arrives in the cycle after a probe cycle.
   `QBT_ASSERT_IMPLY(a_rd_after_probe, clock, reset, rd_vld_ff, $past(state_ff == ST_PROBE))
   // The fourth probe is always followed by the settle cycle.
   `QBT_ASSERT_NEXT(a_probe_to_settle, clock, reset,
                    (state_ff == ST_PROBE) && (probe_ff == DIR_RIGHT), state_ff == ST_SETTLE)
   // A block ends exactly when its last triangle is loaded.
   `QBT_ASSERT_IMPLY(a_emit_ends_last, clock, reset,
                     (state_ff == ST_EMIT) && (state_in == ST_IDLE), tri_load && tri_cur.last)

endmodule

// ===== hw/rtl/qbt_mark_mem.sv =====
// ----------------------------------------------------------------------------
// Split-mark memory
// One-bit-wide synchronous memory with a registered read and a clearing
// sweep that runs through every entry after reset.
// ----------------------------------------------------------------------------
module qbt_mark_mem #(
   parameter int unsigned MAX_LEVELS = qbt_pkg::DEF_MAX_LEVELS,
   parameter int unsigned MAX_SIDE   = (1 << (MAX_LEVELS - 1)) + 1,
   parameter int unsigned DEPTH      = MAX_SIDE * MAX_SIDE,
   parameter int unsigned AW         = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qbt_pkg::mark_ctl_type ctl,
   input  logic [AW-1:0]         addr,
   output logic                  rdata,
   output logic                  clr_busy
);
   import qbt_pkg::*;

   logic          mem_array [0:DEPTH-1];
   logic          rdata_ff;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The sweep owns the port while it runs.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem_array[clr_addr_ff] <= 1'b0;
      end else if (ctl.en && ctl.we) begin
         mem_array[addr] <= ctl.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (!clr_busy_ff && ctl.en && !ctl.we) begin
         rdata_ff <= mem_array[addr];
      end
   end

   assign rdata    = rdata_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// ===== hw/rtl/qbt_vert_unit.sv =====
// ----------------------------------------------------------------------------
// Vertex index unit
// Turns a triangle's point codes into vertex indices and holds the result
// word in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module qbt_vert_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tri_load,
   input  qbt_pkg::tri_type              tri_in,
   input  qbt_pkg::geom_type             geom,
   input  logic [qbt_pkg::LEVEL_W-1:0]   vert_shift,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output qbt_pkg::rsp_type              rsp_data,
   output logic                          slot_free
);
   import qbt_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   function automatic logic [COORD_W-1:0] pt_row(input geom_type g, input logic [3:0] p);
      case (p[3:2])
         SEL_MIN: return g.imin;
         SEL_MID: return g.imid;
         default: return g.imax;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pt_col(input geom_type g, input logic [3:0] p);
      case (p[1:0])
         SEL_MIN: return g.jmin;
         SEL_MID: return g.jmid;
         default: return g.jmax;
      endcase
   endfunction

   always_comb begin
      rsp_data_in.vert_a = vert_index(pt_row(geom, tri_in.pa), pt_col(geom, tri_in.pa),
                                      vert_shift);
      rsp_data_in.vert_b = vert_index(pt_row(geom, tri_in.pb), pt_col(geom, tri_in.pb),
                                      vert_shift);
      rsp_data_in.vert_c = vert_index(pt_row(geom, tri_in.pc), pt_col(geom, tri_in.pc),
                                      vert_shift);
      rsp_data_in.last   = tri_in.last;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tri_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tri_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
